/* src/fnc_pkg.sv */
// Shared types, codes and table builder functions for the frequency/note converter.
// The log2 and exp2 interpolation tables are built from these functions at elaboration time.
// No dependencies.
package fnc_pkg;

  localparam int LOG_TABLE_ENTRIES = 256;
  localparam int A4_NOTE = 69;
  localparam logic [23:0] PITCH_RESET = 24'd112640;

  localparam logic [1:0] FN_NOTE  = 2'd0;
  localparam logic [1:0] FN_CENTS = 2'd1;
  localparam logic [1:0] FN_FREQ  = 2'd2;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_NONE = 2'd1;
  localparam logic [1:0] ST_SAT  = 2'd2;

  typedef logic [24:0] log_tab_t [0:LOG_TABLE_ENTRIES];
  typedef logic [31:0] exp_tab_t [0:LOG_TABLE_ENTRIES];

  typedef struct packed {
    logic [1:0]        func;
    logic signed [8:0] note;
    logic              absent;
    logic              hz_zero;
    logic [23:0]       freq;
    logic              fsat;
  } sb_t;

  typedef struct packed {
    logic signed [48:0] prod;
    logic signed [8:0]  nn;
    logic               nsat;
  } cents_res_t;

  function automatic logic [63:0] isqrt64(input logic [63:0] v);
    logic [63:0] x;
    logic [63:0] res;
    logic [63:0] bt;
    x = v;
    res = 64'd0;
    bt = 64'd1 << 62;
    while (bt > x) bt = bt >> 2;
    while (bt != 64'd0) begin
      if (x >= res + bt) begin
        x = x - (res + bt);
        res = (res >> 1) + bt;
      end else begin
        res = res >> 1;
      end
      bt = bt >> 2;
    end
    return res;
  endfunction

  function automatic log_tab_t build_log_tab();
    log_tab_t tab;
    logic [63:0] x;
    logic [24:0] res;
    for (int i = 0; i < LOG_TABLE_ENTRIES; i++) begin
      x = (64'd1 << 30) + ((64'(i) << 30) / LOG_TABLE_ENTRIES);
      res = 25'd0;
      for (int k = 23; k >= 0; k--) begin
        x = (x * x) >> 30;
        if (x >= (64'd1 << 31)) begin
          x = x >> 1;
          res[k] = 1'b1;
        end
      end
      tab[i] = res;
    end
    tab[LOG_TABLE_ENTRIES] = 25'd1 << 24;
    return tab;
  endfunction

  function automatic exp_tab_t build_exp_tab();
    exp_tab_t tab;
    logic [63:0] c [0:24];
    logic [63:0] u;
    logic [63:0] m;
    c[0] = 64'd1 << 31;
    for (int k = 1; k <= 24; k++) c[k] = isqrt64(c[k-1] << 30);
    for (int j = 0; j < LOG_TABLE_ENTRIES; j++) begin
      u = (64'(j) << 24) / LOG_TABLE_ENTRIES;
      m = 64'd1 << 30;
      for (int k = 1; k <= 24; k++) begin
        if (u[24-k]) m = (m * c[k]) >> 30;
      end
      tab[j] = m[31:0];
    end
    tab[LOG_TABLE_ENTRIES] = 32'd1 << 31;
    return tab;
  endfunction

endpackage

/* src/frequency_note_converter.sv */
// Frequency/note converter top level: eight register stages from an accepted transaction
// to out_valid, throughput one transaction per cycle while the output is not stalled.
// The depth is set by the log2 table pipeline feeding the cents scaler.
// A stall at the output holds only the stages that are full; bubbles still close.
// Synchronous reset empties the pipeline and sets the concert pitch to 440 Hz.
module frequency_note_converter import fnc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write_en,
  input  logic [23:0]       cfg_write_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        func,
  input  logic [23:0]       hz_q8,
  input  logic signed [8:0] given_note,
  input  logic              note_absent,
  output logic              out_valid,
  input  logic              out_stall,
  output logic signed [8:0] nearest_note,
  output logic signed [23:0] cents_x100,
  output logic [23:0]       freq_q8,
  output logic [1:0]        status
);

  logic [23:0]        pitch;
  logic [23:0]        pitch_eff;
  logic [8:1]         v;
  logic [9:1]         en;
  sb_t                sb [1:7];
  sb_t                sb6_next;
  logic [28:0]        lh;
  logic [28:0]        lp;
  logic [23:0]        exp_freq;
  logic               exp_fsat;
  cents_res_t         cres;
  logic [48:0]        cmag;
  logic [25:0]        cq;
  logic               csat;
  logic signed [23:0] cents_c;
  logic signed [8:0]  nn_next;
  logic signed [23:0] cents_next;
  logic [23:0]        freq_next;
  logic [1:0]         status_next;

  assign pitch_eff = (pitch == 24'd0) ? 24'd1 : pitch;

  always_comb begin
    en[9] = !out_stall;
    for (int k = 8; k >= 1; k--) en[k] = !v[k] || en[k+1];
  end

  assign in_stall  = !en[1];
  assign out_valid = v[8];

  always_ff @(posedge clk) begin
    if (rst) begin
      pitch <= PITCH_RESET;
      v     <= '0;
    end else begin
      if (cfg_write_en) pitch <= cfg_write_data;
      for (int k = 1; k <= 8; k++) begin
        if (en[k]) v[k] <= (k == 1) ? in_valid : v[k-1];
      end
    end
  end

  always_comb begin
    sb6_next      = sb[5];
    sb6_next.freq = exp_freq;
    sb6_next.fsat = exp_fsat;
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      sb[1].func    <= func;
      sb[1].note    <= given_note;
      sb[1].absent  <= note_absent;
      sb[1].hz_zero <= hz_q8 == 24'd0;
      sb[1].freq    <= 24'd0;
      sb[1].fsat    <= 1'b0;
    end
    for (int k = 2; k <= 7; k++) begin
      if (en[k]) begin
        sb[k] <= (k == 6) ? sb6_next : sb[k-1];
      end
    end
  end

  fnc_log2 u_log_hz (
    .clk(clk), .en1(en[1]), .en2(en[2]), .en3(en[3]), .value(hz_q8), .log_q24(lh)
  );

  fnc_log2 u_log_pitch (
    .clk(clk), .en1(en[1]), .en2(en[2]), .en3(en[3]), .value(pitch_eff), .log_q24(lp)
  );

  fnc_exp2 u_exp (
    .clk(clk), .en1(en[1]), .en2(en[2]), .en3(en[3]), .en4(en[4]), .en5(en[5]),
    .note(given_note), .pitch(pitch_eff), .freq(exp_freq), .fsat(exp_fsat)
  );

  fnc_cents u_cents (
    .clk(clk), .en4(en[4]), .en5(en[5]), .en6(en[6]), .en7(en[7]),
    .lh(lh), .lp(lp), .func_note(sb[3].func == FN_NOTE), .note(sb[3].note),
    .res(cres)
  );

  always_comb begin
    cmag = cres.prod[48] ? 49'(-cres.prod) : 49'(cres.prod);
    cq = 26'((cmag + (49'd1 << 23)) >> 24);
    if (cres.prod[48]) begin
      csat    = cq > 26'd8388608;
      cents_c = csat ? -24'sd8388608 : 24'(-$signed({1'b0, cq}));
    end else begin
      csat    = cq > 26'd8388607;
      cents_c = csat ? 24'sd8388607 : $signed(cq[23:0]);
    end
  end

  always_comb begin
    nn_next     = sb[7].note;
    cents_next  = 24'sd0;
    freq_next   = 24'd0;
    status_next = ST_NONE;
    case (sb[7].func)
      FN_NOTE: begin
        if (sb[7].hz_zero) begin
          nn_next = 9'sd0;
        end else begin
          nn_next     = cres.nn;
          cents_next  = cents_c;
          status_next = (cres.nsat || csat) ? ST_SAT : ST_OK;
        end
      end
      FN_CENTS: begin
        if (!(sb[7].absent || sb[7].hz_zero)) begin
          cents_next  = cents_c;
          status_next = csat ? ST_SAT : ST_OK;
        end
      end
      FN_FREQ: begin
        freq_next   = sb[7].freq;
        status_next = sb[7].fsat ? ST_SAT : ST_OK;
      end
      default: begin
        status_next = ST_NONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en[8]) begin
      nearest_note <= nn_next;
      cents_x100   <= cents_next;
      freq_q8      <= freq_next;
      status       <= status_next;
    end
  end

endmodule

/* src/fnc_log2.sv */
// Three-stage fixed-point log2: normalize, table lookup, interpolate.
// Depends on fnc_pkg for the log table.
module fnc_log2 import fnc_pkg::*; (
  input  logic        clk,
  input  logic        en1,
  input  logic        en2,
  input  logic        en3,
  input  logic [23:0] value,
  output logic [28:0] log_q24
);

  localparam log_tab_t LOG_TAB = build_log_tab();

  logic [4:0]  e_c;
  logic [53:0] m_c;
  logic [4:0]  e1;
  logic [7:0]  i1;
  logic [21:0] r1;
  logic [4:0]  e2;
  logic [24:0] a2;
  logic [16:0] d2;
  logic [21:0] r2;
  logic [38:0] p3;

  always_comb begin
    e_c = 5'd0;
    for (int b = 0; b < 24; b++) begin
      if (value[b]) e_c = 5'(b);
    end
    m_c = 54'(value) << (5'd30 - e_c);
  end

  assign p3 = 39'(d2) * 39'(r2);

  always_ff @(posedge clk) begin
    if (en1) begin
      e1 <= e_c;
      i1 <= m_c[29:22];
      r1 <= m_c[21:0];
    end
    if (en2) begin
      e2 <= e1;
      a2 <= LOG_TAB[i1];
      d2 <= 17'(LOG_TAB[{1'b0, i1} + 9'd1] - LOG_TAB[i1]);
      r2 <= r1;
    end
    if (en3) begin
      log_q24 <= {e2, 24'd0} + 29'(a2) + 29'(p3[38:22]);
    end
  end

endmodule

/* src/fnc_exp2.sv */
// Five-stage note-to-frequency path: semitone split, exp2 table lookup,
// interpolation, pitch multiply, and rounding shift with saturation.
// Depends on fnc_pkg for the exp table and constants.
module fnc_exp2 import fnc_pkg::*; (
  input  logic              clk,
  input  logic              en1,
  input  logic              en2,
  input  logic              en3,
  input  logic              en4,
  input  logic              en5,
  input  logic signed [8:0] note,
  input  logic [23:0]       pitch,
  output logic [23:0]       freq,
  output logic              fsat
);

  localparam exp_tab_t EXP_TAB = build_exp_tab();

  logic signed [9:0]  d_c;
  logic [8:0]         mag_c;
  logic [6:0]         q3_c;
  logic [1:0]         rem_c;
  logic [21:0]        remk_c;
  logic [28:0]        tm_c;
  logic signed [29:0] t1;
  logic signed [5:0]  ip2;
  logic [31:0]        a2;
  logic [22:0]        d2;
  logic [15:0]        w2;
  logic signed [5:0]  ip3;
  logic [31:0]        mant3;
  logic [38:0]        pw_c;
  logic signed [5:0]  ip4;
  logic [55:0]        prod4;
  logic signed [6:0]  sh_c;
  logic [5:0]         shu_c;
  logic [56:0]        fv_c;

  always_comb begin
    d_c = 10'(note) - 10'(A4_NOTE);
    mag_c = d_c[9] ? 9'(-d_c) : 9'(d_c);
    q3_c = 7'((18'(mag_c) * 18'd171) >> 9);
    rem_c = 2'(mag_c - 9'({q3_c, 1'b0}) - 9'(q3_c));
    case (rem_c)
      2'd1:    remk_c = 22'd1398101;
      2'd2:    remk_c = 22'd2796203;
      default: remk_c = 22'd0;
    endcase
    tm_c = {q3_c, 22'd0} + 29'(remk_c);
  end

  assign pw_c = 39'(d2) * 39'(w2);

  always_comb begin
    sh_c = 7'sd30 - 7'(ip4);
    if (sh_c < 7'sd1) shu_c = 6'd1;
    else shu_c = 6'(sh_c);
    fv_c = (57'(prod4) + (57'd1 << (shu_c - 6'd1))) >> shu_c;
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      t1 <= d_c[9] ? -$signed({1'b0, tm_c}) : $signed({1'b0, tm_c});
    end
    if (en2) begin
      ip2 <= t1[29:24];
      a2  <= EXP_TAB[t1[23:16]];
      d2  <= 23'(EXP_TAB[{1'b0, t1[23:16]} + 9'd1] - EXP_TAB[t1[23:16]]);
      w2  <= t1[15:0];
    end
    if (en3) begin
      ip3   <= ip2;
      mant3 <= a2 + 32'(pw_c >> 16);
    end
    if (en4) begin
      ip4   <= ip3;
      prod4 <= 56'(pitch) * 56'(mant3);
    end
    if (en5) begin
      fsat <= fv_c > 57'hFFFFFF;
      freq <= (fv_c > 57'hFFFFFF) ? 24'hFFFFFF : fv_c[23:0];
    end
  end

endmodule

/* src/fnc_cents.sv */
// Four-stage semitone path: offset scaling, nearest-note rounding, deviation
// from the chosen note, and scaling to hundredths of a cent.
// Depends on fnc_pkg for constants and the result struct.
module fnc_cents import fnc_pkg::*; (
  input  logic              clk,
  input  logic              en4,
  input  logic              en5,
  input  logic              en6,
  input  logic              en7,
  input  logic [28:0]       lh,
  input  logic [28:0]       lp,
  input  logic              func_note,
  input  logic signed [8:0] note,
  output cents_res_t        res
);

  logic signed [29:0] diff_c;
  logic signed [33:0] dx_c;
  logic signed [33:0] s4;
  logic               fn4;
  logic signed [8:0]  note4;
  logic [33:0]        mag_c;
  logic [9:0]         q_c;
  logic signed [11:0] n_c;
  logic signed [33:0] s5;
  logic signed [8:0]  n5;
  logic               nsat5;
  logic               fn5;
  logic signed [8:0]  note5;
  logic signed [8:0]  refn_c;
  logic signed [9:0]  off_c;
  logic signed [34:0] dev6;
  logic signed [8:0]  n6;
  logic               nsat6;

  always_comb begin
    diff_c = $signed({1'b0, lh}) - $signed({1'b0, lp});
    dx_c = 34'(diff_c);
    mag_c = s4[33] ? 34'(-s4) : 34'(s4);
    q_c = 10'((mag_c + (34'd1 << 23)) >> 24);
    n_c = (s4[33] ? -$signed({2'b00, q_c}) : $signed({2'b00, q_c})) + 12'(A4_NOTE);
    refn_c = fn5 ? n5 : note5;
    off_c = 10'(refn_c) - 10'(A4_NOTE);
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      s4    <= (dx_c <<< 3) + (dx_c <<< 2);
      fn4   <= func_note;
      note4 <= note;
    end
    if (en5) begin
      s5    <= s4;
      fn5   <= fn4;
      note5 <= note4;
      if (n_c > 12'sd255) begin
        n5    <= 9'sd255;
        nsat5 <= 1'b1;
      end else if (n_c < -12'sd256) begin
        n5    <= -9'sd256;
        nsat5 <= 1'b1;
      end else begin
        n5    <= 9'(n_c);
        nsat5 <= 1'b0;
      end
    end
    if (en6) begin
      dev6  <= 35'(s5) - (35'(off_c) <<< 24);
      n6    <= n5;
      nsat6 <= nsat5;
    end
    if (en7) begin
      res.prod <= 49'(dev6) * 49'sd10000;
      res.nn   <= n6;
      res.nsat <= nsat6;
    end
  end

endmodule

/* src/fnc_checker.sv */
// Port-level checker for the frequency/note converter and its bind statement.
// Depends on fnc_pkg for status codes.
module fnc_checker import fnc_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              out_valid,
  input logic              out_stall,
  input logic signed [8:0] nearest_note,
  input logic signed [23:0] cents_x100,
  input logic [23:0]       freq_q8,
  input logic [1:0]        status
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(cents_x100) && $stable(freq_q8)
      && $stable(status) && $stable(nearest_note))
    else $error("stalled transaction changed");

  a_none_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_NONE |-> cents_x100 == 24'sd0 && freq_q8 == 24'd0)
    else $error("no-pitch result carries a value");

  a_freq_no_cents: assert property (@(posedge clk) disable iff (rst)
    out_valid && freq_q8 != 24'd0 |-> cents_x100 == 24'sd0)
    else $error("frequency and cents both set");

  a_freq_sat: assert property (@(posedge clk) disable iff (rst)
    out_valid && freq_q8 != 24'd0 && status == ST_SAT |-> freq_q8 == 24'hFFFFFF)
    else $error("saturated frequency not at full scale");

endmodule

bind frequency_note_converter fnc_checker u_fnc_checker (
  .clk(clk), .rst(rst), .out_valid(out_valid), .out_stall(out_stall),
  .nearest_note(nearest_note), .cents_x100(cents_x100), .freq_q8(freq_q8),
  .status(status)
);

/* tb/frequency_note_converter_test.sv */
// Self-checking testbench for the frequency/note converter: a queue-fed driver, a stalling
// receiver and a monitor that checks every result against an internal fixed-point predictor.
// Depends on fnc_pkg and frequency_note_converter.
module frequency_note_converter_test;
  import fnc_pkg::*;

  localparam longint ONE24 = 64'd1 << 24;
  localparam bit [63:0] ONE30 = 64'd1 << 30;
  localparam int NTAB = 256;
  localparam int WATCHDOG_LIMIT = 5000;

  typedef struct {
    logic [1:0]        func;
    logic [23:0]       hz;
    logic signed [8:0] note;
    logic              absent;
  } request_t;

  typedef struct {
    logic signed [8:0]  nn;
    logic signed [23:0] cents;
    logic [23:0]        freq;
    logic [1:0]         st;
  } answer_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write_en = 1'b0;
  logic [23:0] cfg_write_data = 24'd0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] func = 2'd0;
  logic [23:0] hz_q8 = 24'd0;
  logic signed [8:0] given_note = 9'sd0;
  logic note_absent = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [8:0] nearest_note;
  logic signed [23:0] cents_x100;
  logic [23:0] freq_q8;
  logic [1:0] status;

  request_t pending_q[$];
  answer_t answers_q[$];
  bit [63:0] log_tab [0:NTAB];
  bit [63:0] exp_tab [0:NTAB];
  logic [23:0] pitch_reg = PITCH_RESET;
  int errors = 0;
  bit quiet = 1'b0;
  int hold_token = 0;
  int hold_seen = 0;
  int hold_cnt = 0;
  int idle_cycles = 0;

  frequency_note_converter u_dut (
    .clk(clk), .rst(rst), .cfg_write_en(cfg_write_en), .cfg_write_data(cfg_write_data),
    .in_valid(in_valid), .in_stall(in_stall), .func(func), .hz_q8(hz_q8),
    .given_note(given_note), .note_absent(note_absent), .out_valid(out_valid),
    .out_stall(out_stall), .nearest_note(nearest_note), .cents_x100(cents_x100),
    .freq_q8(freq_q8), .status(status)
  );

  always #4 clk = ~clk;

  function automatic bit [63:0] int_sqrt(bit [63:0] v);
    bit [63:0] x, res, bt;
    x = v;
    res = 0;
    bt = 64'd1 << 62;
    while (bt > x) bt = bt >> 2;
    while (bt != 0) begin
      if (x >= res + bt) begin
        x = x - (res + bt);
        res = (res >> 1) + bt;
      end else begin
        res = res >> 1;
      end
      bt = bt >> 2;
    end
    return res;
  endfunction

  function automatic longint round_div(longint num, longint den);
    longint mag;
    longint q;
    mag = num < 0 ? -num : num;
    q = (mag + den / 2) / den;
    return num < 0 ? -q : q;
  endfunction

  function automatic longint log2_fix(logic [23:0] v);
    int e;
    bit [63:0] m, f, p, i, r, a, b;
    e = 23;
    while (e > 0 && v[e] == 1'b0) e--;
    m = 64'(v) << (30 - e);
    f = m - ONE30;
    p = f * NTAB;
    i = p >> 30;
    r = p & (ONE30 - 1);
    a = log_tab[i];
    b = log_tab[i + 1];
    return longint'(e) * ONE24 + longint'(a + (((b - a) * r) >> 30)) - 8 * ONE24;
  endfunction

  function automatic longint scale_cents(longint dev, inout logic [1:0] st);
    longint c;
    c = round_div(dev * 10000, ONE24);
    if (c > 8388607) begin
      c = 8388607;
      st = ST_SAT;
    end
    if (c < -8388608) begin
      c = -8388608;
      st = ST_SAT;
    end
    return c;
  endfunction

  function automatic answer_t convert(request_t rq, logic [23:0] pitch_in);
    answer_t an;
    logic [23:0] pitch;
    longint note, s, n, t, ip, fp, q, j, w, sh;
    bit [63:0] a, b, mant, prod, fr;
    logic [1:0] st;
    pitch = pitch_in == 0 ? 24'd1 : pitch_in;
    note = rq.note;
    st = ST_OK;
    an.nn = rq.note;
    an.cents = 0;
    an.freq = 0;
    if (rq.func == FN_NOTE) begin
      if (rq.hz == 0) begin
        an.nn = 0;
        st = ST_NONE;
      end else begin
        s = 12 * (log2_fix(rq.hz) - log2_fix(pitch));
        n = A4_NOTE + round_div(s, ONE24);
        if (n > 255) begin
          n = 255;
          st = ST_SAT;
        end
        if (n < -256) begin
          n = -256;
          st = ST_SAT;
        end
        an.nn = n;
        an.cents = scale_cents(s - (n - A4_NOTE) * ONE24, st);
      end
    end else if (rq.func == FN_CENTS) begin
      if (rq.absent || rq.hz == 0) begin
        st = ST_NONE;
      end else begin
        s = 12 * (log2_fix(rq.hz) - log2_fix(pitch));
        an.cents = scale_cents(s - (note - A4_NOTE) * ONE24, st);
      end
    end else if (rq.func == FN_FREQ) begin
      t = round_div((note - A4_NOTE) * ONE24, 12);
      if (t >= 0) ip = t / ONE24;
      else ip = -((-t + ONE24 - 1) / ONE24);
      fp = t - ip * ONE24;
      q = fp * NTAB;
      j = q >> 24;
      w = q & (ONE24 - 1);
      a = exp_tab[j];
      b = exp_tab[j + 1];
      mant = a + (((b - a) * 64'(w)) >> 24);
      prod = 64'(pitch) * mant;
      sh = 30 - ip;
      if (sh < 1) sh = 1;
      if (sh > 63) sh = 63;
      fr = (prod + (64'd1 << (sh - 1))) >> sh;
      if (fr > 64'hFFFFFF) begin
        fr = 64'hFFFFFF;
        st = ST_SAT;
      end
      an.freq = fr[23:0];
    end else begin
      st = ST_NONE;
    end
    an.st = st;
    return an;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch on %s: got %0d, expected %0d at %0t", what, got, want, $time);
    errors++;
  endtask

  // Driver: a new transaction may be offered once the current one is gone.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) answers_q.push_back(convert('{func, hz_q8, given_note, note_absent},
                                                 pitch_reg));
      if (pending_q.size() > 0 && (quiet || $urandom_range(0, 99) >= 28)) begin
        request_t rq;
        rq = pending_q.pop_front();
        func <= rq.func;
        hz_q8 <= rq.hz;
        given_note <= rq.note;
        note_absent <= rq.absent;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver stall, including a long hold-off on request.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_stall <= 1'b1;
    end else if (hold_seen != hold_token) begin
      hold_seen <= hold_token;
      hold_cnt <= 300;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !quiet && ($urandom_range(0, 99) < 28);
    end
  end

  // Monitor and watchdog.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (answers_q.size() == 0) begin
          report_mismatch("unexpected transaction", 1, 0);
        end else begin
          answer_t ex;
          ex = answers_q.pop_front();
          if (nearest_note !== ex.nn) report_mismatch("nearest_note", nearest_note, ex.nn);
          if (cents_x100 !== ex.cents) report_mismatch("cents_x100", cents_x100, ex.cents);
          if (freq_q8 !== ex.freq) report_mismatch("freq_q8", freq_q8, ex.freq);
          if (status !== ex.st) report_mismatch("status", status, ex.st);
        end
      end
      if ((out_valid && !out_stall) || (in_valid && !in_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("frequency_note_converter test failed");
        $finish;
      end
    end
  end

  function automatic logic [23:0] pick_hz();
    int sh;
    sh = $urandom_range(0, 23);
    case ($urandom_range(0, 9))
      0: return 24'd0;
      1: return 24'hFFFFFF;
      2, 3: return (pitch_reg << $urandom_range(0, 3)) + $urandom_range(0, 200) - 100;
      default: return $urandom & ((32'd1 << (sh + 1)) - 1);
    endcase
  endfunction

  task automatic add_request(logic [1:0] f, logic [23:0] h, logic signed [8:0] n, logic ab);
    request_t rq;
    rq = '{f, h, n, ab};
    pending_q.push_back(rq);
  endtask

  task automatic add_random(int count);
    logic [1:0] f;
    for (int k = 0; k < count; k++) begin
      f = $urandom_range(0, 19) == 0 ? 2'd3 : 2'($urandom_range(0, 2));
      add_request(f, pick_hz(), 9'($urandom), $urandom_range(0, 3) == 0);
    end
  endtask

  task automatic drain();
    while (pending_q.size() > 0 || answers_q.size() > 0 || in_valid) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic set_pitch(logic [23:0] v);
    @(posedge clk);
    cfg_write_en <= 1'b1;
    cfg_write_data <= v;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    pitch_reg = v;
  endtask

  initial begin
    bit [63:0] x, res, u, m;
    bit [63:0] c [0:24];
    logic [23:0] pitches [0:4];
    for (int i = 0; i < NTAB; i++) begin
      x = ONE30 + ((64'(i) << 30) / NTAB);
      res = 0;
      for (int k = 23; k >= 0; k--) begin
        x = (x * x) >> 30;
        if (x >= (ONE30 << 1)) begin
          x = x >> 1;
          res[k] = 1'b1;
        end
      end
      log_tab[i] = res;
    end
    log_tab[NTAB] = 64'd1 << 24;
    c[0] = ONE30 << 1;
    for (int k = 1; k <= 24; k++) c[k] = int_sqrt(c[k - 1] << 30);
    for (int j = 0; j < NTAB; j++) begin
      u = (64'(j) << 24) / NTAB;
      m = ONE30;
      for (int k = 1; k <= 24; k++) if (u[24 - k]) m = (m * c[k]) >> 30;
      exp_tab[j] = m;
    end
    exp_tab[NTAB] = ONE30 << 1;

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    add_request(FN_NOTE, 24'd0, 9'sd5, 1'b0);
    add_request(FN_NOTE, 24'd1, 9'sd0, 1'b0);
    add_request(FN_NOTE, 24'hFFFFFF, 9'sd0, 1'b1);
    add_request(FN_NOTE, 24'd112640, 9'sd0, 1'b0);
    add_request(FN_NOTE, 24'd116000, 9'sd0, 1'b0);
    add_request(FN_CENTS, 24'd112640, 9'sd69, 1'b1);
    add_request(FN_CENTS, 24'd0, 9'sd69, 1'b0);
    add_request(FN_CENTS, 24'd112640, 9'sd69, 1'b0);
    add_request(FN_CENTS, 24'd1, 9'sd255, 1'b0);
    add_request(FN_CENTS, 24'hFFFFFF, -9'sd256, 1'b0);
    add_request(FN_FREQ, 24'd0, -9'sd256, 1'b0);
    add_request(FN_FREQ, 24'd0, 9'sd255, 1'b1);
    add_request(FN_FREQ, 24'd0, 9'sd69, 1'b0);
    add_request(FN_FREQ, 24'd0, 9'sd0, 1'b0);
    add_request(FN_FREQ, 24'd0, 9'sd120, 1'b0);
    add_request(2'd3, 24'hABCDEF, -9'sd7, 1'b1);
    drain();

    pitches[0] = 24'd1;
    pitches[1] = 24'hFFFFFF;
    pitches[2] = PITCH_RESET;
    pitches[3] = 24'($urandom_range(1, 24'hFFFFFF));
    pitches[4] = 24'd110000;
    for (int p = 0; p < 5; p++) begin
      set_pitch(pitches[p]);
      quiet = (p == 2);
      add_random(190);
      if (p == 3) begin
        repeat (20) @(posedge clk);
        hold_token = hold_token + 1;
      end
      drain();
    end

    if (errors == 0) begin
      $display("frequency_note_converter test passed");
    end else begin
      $display("frequency_note_converter test failed");
    end
    $finish;
  end
endmodule

/* sim.f */
src/fnc_pkg.sv
src/fnc_log2.sv
src/fnc_exp2.sv
src/fnc_cents.sv
src/frequency_note_converter.sv
src/fnc_checker.sv
tb/frequency_note_converter_test.sv
